// File: src/ttbl_pkg.sv
// ----------------------------------------------------------------------------
// ttbl_pkg
// Types, codes and fixed widths shared by the bilinear timing-table lookup.
// ----------------------------------------------------------------------------
package ttbl_pkg;

   localparam int VAL_W  = 24;  // table words and lookup operands
   localparam int DIF_W  = 25;  // signed difference of two 24-bit words
   localparam int MUL_W  = 26;  // shared multiplier operand
   localparam int PROD_W = 52;  // shared multiplier product
   localparam int X_W    = 50;  // one-axis partial sum
   localparam int NUM_W  = 76;  // full numerator
   localparam int DEN_W  = 48;  // denominator magnitude
   localparam int CNT_W  = 7;   // sequencer step counter
   localparam int OP_W   = 4;

   localparam logic [CNT_W-1:0] FETCH_LAST = 7'd8;
   localparam logic [CNT_W-1:0] MUL_LAST   = 7'd9;
   localparam logic [CNT_W-1:0] DIV_LAST   = 7'(NUM_W - 1);

   localparam logic [OP_W-1:0] OP_IDLE     = 4'd0;
   localparam logic [OP_W-1:0] OP_LOAD     = 4'd1;
   localparam logic [OP_W-1:0] OP_SRCH_RD  = 4'd2;
   localparam logic [OP_W-1:0] OP_SRCH_CMP = 4'd3;
   localparam logic [OP_W-1:0] OP_FETCH    = 4'd4;
   localparam logic [OP_W-1:0] OP_MUL      = 4'd5;
   localparam logic [OP_W-1:0] OP_PREP     = 4'd6;
   localparam logic [OP_W-1:0] OP_DIV      = 4'd7;
   localparam logic [OP_W-1:0] OP_ROUND    = 4'd8;
   localparam logic [OP_W-1:0] OP_FINISH   = 4'd9;

   localparam logic [1:0] SEL_DELAY = 2'd0;
   localparam logic [1:0] SEL_SLEW  = 2'd1;
   localparam logic [1:0] SEL_SAXIS = 2'd2;
   localparam logic [1:0] SEL_LAXIS = 2'd3;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_SAT  = 2'd1;
   localparam logic [1:0] ST_ZERO = 2'd2;

   typedef struct packed {
      logic             mode;
      logic [1:0]       table_sel;
      logic [2:0]       row;
      logic [2:0]       col;
      logic [VAL_W-1:0] write_value;
      logic [VAL_W-1:0] input_slew;
      logic [VAL_W-1:0] load_cap;
      logic             want_delay;
   } req_type;

   typedef struct packed {
      logic signed [31:0] result;
      logic [1:0]         status;
   } rsp_type;

   typedef struct packed {
      logic [OP_W-1:0]  op;
      logic             axis;   // 0 slew axis, 1 load axis
      logic [CNT_W-1:0] step;
   } cmd_type;

   typedef struct packed {
      logic is_write;
      logic zero_span;
   } stat_type;

endpackage

// File: src/ttbl_ram.sv
// ----------------------------------------------------------------------------
// ttbl_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ttbl_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

// File: src/ttbl_ctrl.sv
// ----------------------------------------------------------------------------
// ttbl_ctrl
// Sequencer: axis search, operand fetch, multiply, divide, round, result.
// ----------------------------------------------------------------------------
module ttbl_ctrl #(
   parameter int TABLE_DIM = 7
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   input  logic [$clog2(TABLE_DIM+1)-1:0]        n_slew,
   input  logic [$clog2(TABLE_DIM+1)-1:0]        n_load,
   input  ttbl_pkg::stat_type                    stat,
   output ttbl_pkg::cmd_type                     cmd
);
   import ttbl_pkg::*;

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_BRANCH   = 4'd1;
   localparam logic [3:0] S_SRCH_RD  = 4'd2;
   localparam logic [3:0] S_SRCH_CMP = 4'd3;
   localparam logic [3:0] S_FETCH    = 4'd4;
   localparam logic [3:0] S_CHECK    = 4'd5;
   localparam logic [3:0] S_MUL      = 4'd6;
   localparam logic [3:0] S_PREP     = 4'd7;
   localparam logic [3:0] S_DIV      = 4'd8;
   localparam logic [3:0] S_ROUND    = 4'd9;
   localparam logic [3:0] S_OUT      = 4'd10;

   logic [3:0]       state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             axis_ff, axis_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0] last_pt;

   assign last_pt = axis_ff ? CNT_W'(n_load) - 1'b1 : CNT_W'(n_slew) - 1'b1;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      axis_in      = axis_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      cmd.op       = OP_IDLE;
      cmd.axis     = axis_ff;
      cmd.step     = cnt_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               state_in = S_BRANCH;
            end
         end
         S_BRANCH: begin
            cnt_in  = '0;
            axis_in = 1'b0;
            state_in = stat.is_write ? S_OUT : S_SRCH_RD;
         end
         S_SRCH_RD: begin
            cmd.op   = OP_SRCH_RD;
            state_in = S_SRCH_CMP;
         end
         S_SRCH_CMP: begin
            cmd.op = OP_SRCH_CMP;
            if (cnt_ff == last_pt) begin
               cnt_in = '0;
               if (axis_ff) begin
                  state_in = S_FETCH;
               end else begin
                  axis_in  = 1'b1;
                  state_in = S_SRCH_RD;
               end
            end else begin
               cnt_in   = cnt_ff + 1'b1;
               state_in = S_SRCH_RD;
            end
         end
         S_FETCH: begin
            cmd.op = OP_FETCH;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == FETCH_LAST) begin
               cnt_in   = '0;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            state_in = stat.zero_span ? S_OUT : S_MUL;
         end
         S_MUL: begin
            cmd.op = OP_MUL;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == MUL_LAST) begin
               cnt_in   = '0;
               state_in = S_PREP;
            end
         end
         S_PREP: begin
            cmd.op   = OP_PREP;
            state_in = S_DIV;
         end
         S_DIV: begin
            cmd.op = OP_DIV;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == DIV_LAST) begin
               cnt_in   = '0;
               state_in = S_ROUND;
            end
         end
         S_ROUND: begin
            cmd.op   = OP_ROUND;
            state_in = S_OUT;
         end
         S_OUT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.op       = OP_FINISH;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         axis_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         axis_ff      <= axis_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
endmodule

// File: src/ttbl_datapath.sv
// ----------------------------------------------------------------------------
// ttbl_datapath
// Table RAMs, axis bracket search, shared multiplier and serial divider.
// ----------------------------------------------------------------------------
module ttbl_datapath #(
   parameter int TABLE_DIM = 7
) (
   input  logic                           clock,
   input  ttbl_pkg::cmd_type              cmd,
   input  ttbl_pkg::req_type              req_data,
   input  logic [$clog2(TABLE_DIM+1)-1:0] n_slew,
   input  logic [$clog2(TABLE_DIM+1)-1:0] n_load,
   output ttbl_pkg::stat_type             stat,
   output ttbl_pkg::rsp_type              rsp_data
);
   import ttbl_pkg::*;

   localparam int CW   = $clog2(TABLE_DIM + 1);
   localparam int IW   = (TABLE_DIM > 2) ? $clog2(TABLE_DIM) : 1;
   localparam int GDEP = 2 * TABLE_DIM * TABLE_DIM;
   localparam int ADEP = 2 * TABLE_DIM;
   localparam int GAW  = $clog2(GDEP);
   localparam int AAW  = $clog2(ADEP);

   req_type                item_ff;
   logic                   found_ff [2];
   logic [CW-1:0]          u_ff [2];
   logic [VAL_W-1:0]       t1_ff, t2_ff, c1_ff, c2_ff;
   logic [VAL_W-1:0]       v11_ff, v12_ff, v21_ff, v22_ff;
   logic signed [PROD_W-1:0] prod_ff, den_ff;
   logic signed [X_W-1:0]  x_ff, y_ff;
   logic signed [NUM_W-1:0] num_ff;
   logic [NUM_W-1:0]       quo_ff;
   logic [DEN_W-1:0]       rem_ff, dmag_ff;
   logic                   qneg_ff;
   rsp_type                rsp_ff;

   logic                   grid_we, axis_we;
   logic [GAW-1:0]         grid_waddr, grid_raddr;
   logic [AAW-1:0]         axis_waddr, axis_raddr;
   logic [VAL_W-1:0]       grid_rd, axis_rd, key;
   logic [IW-1:0]          i1, j1;
   logic signed [DIF_W-1:0] dt2, ds1, dc2, dl1, dts, dcs;
   logic signed [MUL_W-1:0] mul_a, mul_b;
   logic signed [NUM_W-1:0] prod_ext;
   logic [NUM_W-1:0]       mag;
   logic [DEN_W:0]         rem_sh;
   logic                   take;
   logic [NUM_W-1:0]       limit;
   logic                   sat;
   logic [31:0]            mag32;

   function automatic logic [IW-1:0] lower_idx(input logic [CW-1:0] u, input logic [CW-1:0] n);
      logic [IW-1:0] r;
      if (u == '0) begin
         r = '0;
      end else if (u > n - 1'b1) begin
         r = IW'(n - CW'(2));
      end else begin
         r = IW'(u - 1'b1);
      end
      return r;
   endfunction

   function automatic logic signed [DIF_W-1:0] diff(input logic [VAL_W-1:0] a,
                                                    input logic [VAL_W-1:0] b);
      return $signed({1'b0, a}) - $signed({1'b0, b});
   endfunction

   // write port: one table word per write item, taken on the accept beat
   always_comb begin
      grid_we    = 1'b0;
      axis_we    = 1'b0;
      grid_waddr = GAW'(int'(req_data.table_sel[0]) * TABLE_DIM * TABLE_DIM
                        + int'(req_data.row) * TABLE_DIM + int'(req_data.col));
      axis_waddr = AAW'(int'(req_data.table_sel[0]) * TABLE_DIM + int'(req_data.row));
      if (cmd.op == OP_LOAD && !req_data.mode && int'(req_data.row) < TABLE_DIM) begin
         case (req_data.table_sel)
            SEL_DELAY, SEL_SLEW: grid_we = (int'(req_data.col) < TABLE_DIM);
            SEL_SAXIS, SEL_LAXIS: axis_we = 1'b1;
            default: ;
         endcase
      end
   end

   assign i1 = lower_idx(u_ff[0], n_slew);
   assign j1 = lower_idx(u_ff[1], n_load);

   // read addresses: search walks one axis, fetch takes the bracketing axis points and corners
   always_comb begin
      axis_raddr = AAW'(int'(cmd.axis) * TABLE_DIM + int'(cmd.step));
      grid_raddr = GAW'(int'(!item_ff.want_delay) * TABLE_DIM * TABLE_DIM
                        + (int'(i1) + int'(cmd.step[1])) * TABLE_DIM
                        + int'(j1) + int'(cmd.step[0]));
      if (cmd.op == OP_FETCH) begin
         if (cmd.step[1]) begin
            axis_raddr = AAW'(TABLE_DIM + int'(j1) + int'(cmd.step[0]));
         end else begin
            axis_raddr = AAW'(int'(i1) + int'(cmd.step[0]));
         end
      end
   end

   ttbl_ram #(.WIDTH(VAL_W), .DEPTH(GDEP)) u_grid (
      .clock (clock),
      .we    (grid_we),
      .waddr (grid_waddr),
      .wdata (req_data.write_value),
      .raddr (grid_raddr),
      .rdata (grid_rd)
   );

   ttbl_ram #(.WIDTH(VAL_W), .DEPTH(ADEP)) u_axis (
      .clock (clock),
      .we    (axis_we),
      .waddr (axis_waddr),
      .wdata (req_data.write_value),
      .raddr (axis_raddr),
      .rdata (axis_rd)
   );

   assign key = cmd.axis ? item_ff.load_cap : item_ff.input_slew;

   assign dt2 = diff(t2_ff, item_ff.input_slew);
   assign ds1 = diff(item_ff.input_slew, t1_ff);
   assign dc2 = diff(c2_ff, item_ff.load_cap);
   assign dl1 = diff(item_ff.load_cap, c1_ff);
   assign dts = diff(t2_ff, t1_ff);
   assign dcs = diff(c2_ff, c1_ff);

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.step)
         7'd0: begin mul_a = $signed({2'b00, v11_ff}); mul_b = MUL_W'(dt2); end
         7'd1: begin mul_a = $signed({2'b00, v21_ff}); mul_b = MUL_W'(ds1); end
         7'd2: begin mul_a = $signed({2'b00, v12_ff}); mul_b = MUL_W'(ds1 - ds1 + dt2); end
         7'd3: begin mul_a = $signed({2'b00, v22_ff}); mul_b = MUL_W'(ds1); end
         7'd4: begin mul_a = MUL_W'(dcs); mul_b = MUL_W'(dts); end
         7'd5: begin mul_a = $signed({1'b0, x_ff[24:0]}); mul_b = MUL_W'(dc2); end
         7'd6: begin mul_a = $signed({x_ff[X_W-1], x_ff[X_W-1:25]}); mul_b = MUL_W'(dc2); end
         7'd7: begin mul_a = $signed({1'b0, y_ff[24:0]}); mul_b = MUL_W'(dl1); end
         7'd8: begin mul_a = $signed({y_ff[X_W-1], y_ff[X_W-1:25]}); mul_b = MUL_W'(dl1); end
         default: ;
      endcase
   end

   assign prod_ext = NUM_W'(prod_ff);
   assign mag      = num_ff[NUM_W-1] ? NUM_W'(-num_ff) : NUM_W'(num_ff);
   assign rem_sh   = {rem_ff, quo_ff[NUM_W-1]};
   assign take     = rem_sh >= {1'b0, dmag_ff};
   assign limit    = qneg_ff ? NUM_W'(33'h080000000) : NUM_W'(33'h07fffffff);
   assign sat      = quo_ff > limit;
   assign mag32    = sat ? limit[31:0] : quo_ff[31:0];

   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_LOAD: begin
            item_ff     <= req_data;
            found_ff[0] <= 1'b0;
            found_ff[1] <= 1'b0;
            u_ff[0]     <= n_slew;
            u_ff[1]     <= n_load;
         end
         OP_SRCH_CMP: begin
            // first point above the key marks the upper bound
            if (!found_ff[cmd.axis] && axis_rd > key) begin
               found_ff[cmd.axis] <= 1'b1;
               u_ff[cmd.axis]     <= CW'(cmd.step);
            end
         end
         OP_FETCH: begin
            case (cmd.step)
               7'd1: t1_ff  <= axis_rd;
               7'd2: t2_ff  <= axis_rd;
               7'd3: c1_ff  <= axis_rd;
               7'd4: c2_ff  <= axis_rd;
               7'd5: v11_ff <= grid_rd;
               7'd6: v12_ff <= grid_rd;
               7'd7: v21_ff <= grid_rd;
               7'd8: v22_ff <= grid_rd;
               default: ;
            endcase
         end
         OP_MUL: begin
            prod_ff <= mul_a * mul_b;
            case (cmd.step)
               7'd1: x_ff   <= X_W'(prod_ff);
               7'd2: x_ff   <= x_ff + X_W'(prod_ff);
               7'd3: y_ff   <= X_W'(prod_ff);
               7'd4: y_ff   <= y_ff + X_W'(prod_ff);
               7'd5: den_ff <= prod_ff;
               7'd6: num_ff <= prod_ext;
               7'd7: num_ff <= num_ff + (prod_ext <<< 25);
               7'd8: num_ff <= num_ff + prod_ext;
               7'd9: num_ff <= num_ff + (prod_ext <<< 25);
               default: ;
            endcase
         end
         OP_PREP: begin
            quo_ff  <= mag;
            rem_ff  <= '0;
            dmag_ff <= den_ff[PROD_W-1] ? DEN_W'(-den_ff) : DEN_W'(den_ff);
            qneg_ff <= num_ff[NUM_W-1] ^ den_ff[PROD_W-1];
         end
         OP_DIV: begin
            rem_ff <= take ? DEN_W'(rem_sh - {1'b0, dmag_ff}) : DEN_W'(rem_sh);
            quo_ff <= {quo_ff[NUM_W-2:0], take};
         end
         OP_ROUND: begin
            // round half away from zero on the magnitude
            quo_ff <= quo_ff + NUM_W'(rem_ff >= dmag_ff - rem_ff);
         end
         OP_FINISH: begin
            if (item_ff.mode == 1'b0) begin
               rsp_ff.result <= '0;
               rsp_ff.status <= ST_OK;
            end else if (dts == '0 || dcs == '0) begin
               rsp_ff.result <= '0;
               rsp_ff.status <= ST_ZERO;
            end else begin
               rsp_ff.result <= qneg_ff ? $signed(-mag32) : $signed(mag32);
               rsp_ff.status <= sat ? ST_SAT : ST_OK;
            end
         end
         default: ;
      endcase
   end

   assign stat.is_write  = ~item_ff.mode;
   assign stat.zero_span = (dts == '0) || (dcs == '0);
   assign rsp_data       = rsp_ff;
endmodule

// File: src/timing_table_bilinear_lookup_core.sv
// Write item: accepted in idle, then passes the branch and output states, where its
// result is registered; the next item is taken back in idle. Lookup time is set by
// the point-by-point axis search over both axes and the 76-step serial divider.
// One item in flight; the next is taken while its result waits in the output register.
// Synchronous reset restores both point counts to 7 and drops any pending result;
// table contents are undefined until written.
// ----------------------------------------------------------------------------
// timing_table_bilinear_lookup_core
// Bilinear lookup of a delay / output-slew grid against slew and load axes.
// ----------------------------------------------------------------------------
module timing_table_bilinear_lookup_core #(
   parameter int TABLE_DIM = 7
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ttbl_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ttbl_pkg::rsp_type rsp_data,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [2:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);
   import ttbl_pkg::*;

   localparam int CW = $clog2(TABLE_DIM + 1);

   logic [2:0]    slew_pts_ff, load_pts_ff;
   logic [CW-1:0] n_slew, n_load;
   cmd_type       cmd;
   stat_type      stat;

   function automatic logic [CW-1:0] clamp_pts(input logic [2:0] v);
      int n;
      n = int'(v);
      if (n < 2) n = 2;
      if (n > TABLE_DIM) n = TABLE_DIM;
      return CW'(n);
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         slew_pts_ff <= 3'd7;
         load_pts_ff <= 3'd7;
      end else if (psel && penable && pwrite) begin
         if (paddr[2]) begin
            load_pts_ff <= pwdata[2:0];
         end else begin
            slew_pts_ff <= pwdata[2:0];
         end
      end
   end

   assign prdata = {29'd0, paddr[2] ? load_pts_ff : slew_pts_ff};
   assign pready = 1'b1;
   assign n_slew = clamp_pts(slew_pts_ff);
   assign n_load = clamp_pts(load_pts_ff);

   ttbl_ctrl #(.TABLE_DIM(TABLE_DIM)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .n_slew    (n_slew),
      .n_load    (n_load),
      .stat      (stat),
      .cmd       (cmd)
   );

   ttbl_datapath #(.TABLE_DIM(TABLE_DIM)) u_dp (
      .clock    (clock),
      .cmd      (cmd),
      .req_data (req_data),
      .n_slew   (n_slew),
      .n_load   (n_load),
      .stat     (stat),
      .rsp_data (rsp_data)
   );
endmodule

// File: src/ttbl_checker.sv
// ----------------------------------------------------------------------------
// ttbl_checker
// Port-level checks for the timing-table lookup core.
// ----------------------------------------------------------------------------
module ttbl_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input ttbl_pkg::rsp_type rsp_data
);
   import ttbl_pkg::*;

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result beat changed while stalled");

   // one item at a time
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input taken while an item is in flight");

   a_zero_span: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == ST_ZERO |-> rsp_data.result == 32'sd0)
      else $error("zero-spacing result not zero");

   a_sat_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == ST_SAT |->
         rsp_data.result == 32'sh7fffffff || rsp_data.result == 32'sh80000000)
      else $error("saturated result not at a rail");
endmodule

bind timing_table_bilinear_lookup_core ttbl_checker u_ttbl_checker (.*);
